>>> hw/rtl/wsd_pkg.sv
package wsd_pkg;

  // Width of the payload length field on the result side
  localparam int LenFieldW = 63;

  // Depth of the op queue between parser and executor
  localparam int OpQDepth = 4;

  // Header parser phases
  typedef enum logic [2:0] {
    PhHdr0 = 3'd0,
    PhHdr1 = 3'd1,
    PhExt  = 3'd2,
    PhKey  = 3'd3,
    PhData = 3'd4
  } phase_e;

  // Opcodes of the first header byte
  localparam logic [3:0] OpcCont  = 4'h0;
  localparam logic [3:0] OpcText  = 4'h1;
  localparam logic [3:0] OpcBin   = 4'h2;
  localparam logic [3:0] OpcClose = 4'h8;

  // Frame class codes
  localparam logic [2:0] ClsCont  = 3'd0;
  localparam logic [2:0] ClsText  = 3'd1;
  localparam logic [2:0] ClsBin   = 3'd2;
  localparam logic [2:0] ClsClose = 3'd3;
  localparam logic [2:0] ClsOther = 3'd4;

  // 7-bit length codes that select an extended length
  localparam logic [6:0] Len16Code = 7'd126;
  localparam logic [6:0] Len64Code = 7'd127;

  // Extended length and key byte counts
  localparam logic [3:0] Ext16Bytes = 4'd2;
  localparam logic [3:0] Ext64Bytes = 4'd8;
  localparam logic [3:0] KeyBytes   = 4'd4;

  // Result kinds
  localparam logic KindHeader  = 1'b0;
  localparam logic KindPayload = 1'b1;

  // One op from parser to executor
  typedef struct packed {
    logic                 kind;
    logic                 last;
    logic [2:0]           cls;
    logic                 fin;
    logic                 masked;
    logic [LenFieldW-1:0] length;
    logic [7:0]           data;
    logic [7:0]           key;
  } op_t;

  // One result beat
  typedef struct packed {
    logic                 kind;
    logic [2:0]           cls;
    logic                 fin;
    logic                 masked;
    logic [LenFieldW-1:0] length;
    logic [7:0]           data;
    logic                 last;
  } res_t;

  function automatic logic [2:0] class_of(input logic [7:0] b0);
    logic [2:0] cls;
    unique case (b0[3:0])
      OpcCont:  cls = ClsCont;
      OpcText:  cls = ClsText;
      OpcBin:   cls = ClsBin;
      OpcClose: cls = ClsClose;
      default:  cls = ClsOther;
    endcase
    return cls;
  endfunction

endpackage

>>> hw/rtl/websocket_frame_deframer_core.sv
// WebSocket frame deframer: raw frame bytes in, header and unmasked payload beats out.
// Input channel: drive in_byte_i and raise push; a beat is taken on a clock edge
// where push is high and full is low. One byte per cycle is taken sustained while full stays low.
// Result channel: while empty is low the oldest result sits on the result ports;
// raise pop to take it. kind_o is 0 for the header beat of a frame, 1 for a
// payload beat; last_o marks the final beat of a frame (the header beat if the
// payload is empty). Only the last header byte of a frame gives a result.
// Path: the op for a result enters the op queue at the edge that takes its byte,
// and the executor moves it into the output register once that register is free
// (empty or popped). Throughput is one result per cycle while pop keeps up; the
// parser loop is a registered state update.
// Lengths over LEN_BITS (capped at 63) bits saturate to all ones; bit 63 is dropped.
// Reset (rst_ni low, async) empties the op queue and output register and puts
// the parser at the first header byte of a frame.
// Receiver stall: results pile into the output register and a 4-entry op queue;
// once the queue fills, full rises and the byte stream is held off.
module websocket_frame_deframer_core #(
  parameter int LEN_BITS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    in_byte_i,
  output logic                          empty,
  input  logic                          pop,
  output logic                          kind_o,
  output logic [2:0]                    frame_class_o,
  output logic                          final_fragment_o,
  output logic                          is_masked_o,
  output logic [wsd_pkg::LenFieldW-1:0] payload_length_o,
  output logic [7:0]                    data_byte_o,
  output logic                          last_o
);

  logic          in_beat;
  logic          op_push;
  wsd_pkg::op_t  op_in;
  wsd_pkg::op_t  op_out;
  logic          op_empty;
  logic          op_ready;
  logic          op_pop;
  wsd_pkg::res_t res;

  // front: header parse, length decode, key capture
  assign in_beat = push && !full;

  wsd_front #(
    .LEN_BITS (LEN_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_beat),
    .in_byte_i  (in_byte_i),
    .op_valid_o (op_push),
    .op_o       (op_in)
  );

  // op queue decouples parser from result delivery
  wsd_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (op_push),
    .wr_data_i (op_in),
    .full_o    (full),
    .rd_i      (op_pop),
    .rd_data_o (op_out),
    .empty_o   (op_empty)
  );

  assign op_pop = op_ready && !op_empty;

  // back: frame context, unmasking, output register
  wsd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (!op_empty),
    .op_i       (op_out),
    .op_ready_o (op_ready),
    .pop_i      (pop),
    .empty_o    (empty),
    .res_o      (res)
  );

  assign kind_o           = res.kind;
  assign frame_class_o    = res.cls;
  assign final_fragment_o = res.fin;
  assign is_masked_o      = res.masked;
  assign payload_length_o = res.length;
  assign data_byte_o      = res.data;
  assign last_o           = res.last;

endmodule

>>> hw/rtl/wsd_front.sv
module wsd_front #(
  parameter int LEN_BITS = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [7:0]      in_byte_i,
  output logic            op_valid_o,
  output wsd_pkg::op_t    op_o
);

  localparam int LenW = (LEN_BITS > wsd_pkg::LenFieldW) ? wsd_pkg::LenFieldW : LEN_BITS;
  localparam logic [wsd_pkg::LenFieldW-1:0] LenMax =
    (LenW >= wsd_pkg::LenFieldW) ? '1 :
    ((wsd_pkg::LenFieldW'(1) << LenW) - wsd_pkg::LenFieldW'(1));

  wsd_pkg::phase_e phase_q, phase_d;
  logic [7:0]                    fhb_q, fhb_d;
  logic                          mask_q, mask_d;
  logic [3:0]                    hpos_q, hpos_d;
  logic [wsd_pkg::LenFieldW-1:0] acc_q, acc_d;
  logic [31:0]                   key_q, key_d;
  logic [1:0]                    kidx_q, kidx_d;
  logic [LenW-1:0]               rem_q, rem_d;

  logic [6:0]                    l7;
  logic                          l7_ext;
  logic [wsd_pkg::LenFieldW-1:0] acc_shift;
  logic [wsd_pkg::LenFieldW-1:0] acc_fin;
  logic [wsd_pkg::LenFieldW-1:0] len_sat;
  logic                          len_zero;
  logic                          rem_last;
  logic [7:0]                    key_sel;

  // Shared datapath terms
  always_comb begin
    l7        = in_byte_i[6:0];
    l7_ext    = (l7 == wsd_pkg::Len16Code) || (l7 == wsd_pkg::Len64Code);
    acc_shift = {acc_q[wsd_pkg::LenFieldW-9:0], in_byte_i};
    unique case (phase_q)
      wsd_pkg::PhHdr1: acc_fin = wsd_pkg::LenFieldW'(l7);
      wsd_pkg::PhExt:  acc_fin = acc_shift;
      default:         acc_fin = acc_q;
    endcase
    len_sat  = (acc_fin > LenMax) ? LenMax : acc_fin;
    len_zero = (len_sat == '0);
    rem_last = (rem_q <= LenW'(1));
    unique case (kidx_q)
      2'd0:    key_sel = key_q[31:24];
      2'd1:    key_sel = key_q[23:16];
      2'd2:    key_sel = key_q[15:8];
      default: key_sel = key_q[7:0];
    endcase
  end

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (in_valid_i) begin
      unique case (phase_q)
        wsd_pkg::PhHdr0: phase_d = wsd_pkg::PhHdr1;
        wsd_pkg::PhHdr1: begin
          if (l7_ext) begin
            phase_d = wsd_pkg::PhExt;
          end else if (in_byte_i[7]) begin
            phase_d = wsd_pkg::PhKey;
          end else begin
            phase_d = len_zero ? wsd_pkg::PhHdr0 : wsd_pkg::PhData;
          end
        end
        wsd_pkg::PhExt: begin
          if (hpos_q == 4'd1) begin
            if (mask_q) begin
              phase_d = wsd_pkg::PhKey;
            end else begin
              phase_d = len_zero ? wsd_pkg::PhHdr0 : wsd_pkg::PhData;
            end
          end
        end
        wsd_pkg::PhKey: begin
          if (hpos_q == 4'd1) begin
            phase_d = len_zero ? wsd_pkg::PhHdr0 : wsd_pkg::PhData;
          end
        end
        wsd_pkg::PhData: begin
          if (rem_last) begin
            phase_d = wsd_pkg::PhHdr0;
          end
        end
        default: phase_d = wsd_pkg::PhHdr1;
      endcase
    end
  end

  // Datapath registers and ops
  always_comb begin
    logic finish;
    finish     = 1'b0;
    fhb_d      = fhb_q;
    mask_d     = mask_q;
    hpos_d     = hpos_q;
    acc_d      = acc_q;
    key_d      = key_q;
    kidx_d     = kidx_q;
    rem_d      = rem_q;
    op_valid_o = 1'b0;

    op_o.kind   = wsd_pkg::KindHeader;
    op_o.last   = len_zero;
    op_o.cls    = wsd_pkg::class_of(fhb_q);
    op_o.fin    = fhb_q[7];
    op_o.masked = (phase_q == wsd_pkg::PhHdr1) ? in_byte_i[7] : mask_q;
    op_o.length = len_sat;
    op_o.data   = in_byte_i;
    op_o.key    = key_sel;

    if (in_valid_i) begin
      unique case (phase_q)
        wsd_pkg::PhHdr1: begin
          mask_d = in_byte_i[7];
          if (l7 == wsd_pkg::Len16Code) begin
            hpos_d = wsd_pkg::Ext16Bytes;
            acc_d  = '0;
          end else if (l7 == wsd_pkg::Len64Code) begin
            hpos_d = wsd_pkg::Ext64Bytes;
            acc_d  = '0;
          end else begin
            acc_d = acc_fin;
            if (in_byte_i[7]) begin
              hpos_d = wsd_pkg::KeyBytes;
            end else begin
              finish = 1'b1;
            end
          end
        end
        wsd_pkg::PhExt: begin
          // top bit of a 64-bit length drops off the 63-bit accumulator
          acc_d  = acc_shift;
          hpos_d = hpos_q - 4'd1;
          if (hpos_q == 4'd1) begin
            if (mask_q) begin
              hpos_d = wsd_pkg::KeyBytes;
            end else begin
              finish = 1'b1;
            end
          end
        end
        wsd_pkg::PhKey: begin
          key_d  = {key_q[23:0], in_byte_i};
          hpos_d = hpos_q - 4'd1;
          if (hpos_q == 4'd1) begin
            finish = 1'b1;
          end
        end
        wsd_pkg::PhData: begin
          op_valid_o = 1'b1;
          op_o.kind  = wsd_pkg::KindPayload;
          op_o.last  = rem_last;
          kidx_d     = kidx_q + 2'd1;
          rem_d      = (rem_q == '0) ? '0 : (rem_q - LenW'(1));
        end
        default: begin
          // first header byte of a new frame
          fhb_d  = in_byte_i;
          mask_d = 1'b0;
          hpos_d = '0;
          acc_d  = '0;
          key_d  = '0;
          kidx_d = '0;
          rem_d  = '0;
        end
      endcase
      if (finish) begin
        op_valid_o = 1'b1;
        acc_d      = len_sat;
        kidx_d     = '0;
        rem_d      = len_sat[LenW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= wsd_pkg::PhHdr0;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fhb_q  <= fhb_d;
    mask_q <= mask_d;
    hpos_q <= hpos_d;
    acc_q  <= acc_d;
    key_q  <= key_d;
    kidx_q <= kidx_d;
    rem_q  <= rem_d;
  end

endmodule

>>> hw/rtl/wsd_fifo.sv
module wsd_fifo (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         wr_i,
  input  wsd_pkg::op_t wr_data_i,
  output logic         full_o,
  input  logic         rd_i,
  output wsd_pkg::op_t rd_data_o,
  output logic         empty_o
);

  localparam int Depth = wsd_pkg::OpQDepth;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  wsd_pkg::op_t    mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (wr_i) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : (wptr_q + PtrW'(1));
    end
    if (rd_i) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : (rptr_q + PtrW'(1));
    end
    unique case ({wr_i, rd_i})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

endmodule

>>> hw/rtl/wsd_back.sv
module wsd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          op_valid_i,
  input  wsd_pkg::op_t  op_i,
  output logic          op_ready_o,
  input  logic          pop_i,
  output logic          empty_o,
  output wsd_pkg::res_t res_o
);

  logic                          res_valid_q, res_valid_d;
  wsd_pkg::res_t                 res_q, res_d;
  logic [2:0]                    cls_q, cls_d;
  logic                          fin_q, fin_d;
  logic                          masked_q, masked_d;
  logic [wsd_pkg::LenFieldW-1:0] len_q, len_d;
  logic                          take;

  assign op_ready_o = !res_valid_q || pop_i;
  assign take       = op_valid_i && op_ready_o;
  assign empty_o    = !res_valid_q;
  assign res_o      = res_q;

  always_comb begin
    res_valid_d = res_valid_q;
    res_d       = res_q;
    cls_d       = cls_q;
    fin_d       = fin_q;
    masked_d    = masked_q;
    len_d       = len_q;
    if (take) begin
      res_valid_d = 1'b1;
      res_d.kind  = op_i.kind;
      res_d.last  = op_i.last;
      if (op_i.kind == wsd_pkg::KindHeader) begin
        // latch frame context for the payload beats that follow
        cls_d        = op_i.cls;
        fin_d        = op_i.fin;
        masked_d     = op_i.masked;
        len_d        = op_i.length;
        res_d.cls    = op_i.cls;
        res_d.fin    = op_i.fin;
        res_d.masked = op_i.masked;
        res_d.length = op_i.length;
        res_d.data   = '0;
      end else begin
        res_d.cls    = cls_q;
        res_d.fin    = fin_q;
        res_d.masked = masked_q;
        res_d.length = len_q;
        res_d.data   = op_i.data ^ op_i.key;
      end
    end else if (pop_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q    <= res_d;
    cls_q    <= cls_d;
    fin_q    <= fin_d;
    masked_q <= masked_d;
    len_q    <= len_d;
  end

endmodule
